// ===== hw/rtl/active_expired_priority_scheduler_unit_macros.svh =====
// Assertion shorthands for the scheduler; clk and rst_n come from the user scope.
`ifndef ACTIVE_EXPIRED_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define ACTIVE_EXPIRED_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define AEPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Next-cycle implication, checked out of reset
`define AEPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== hw/rtl/aeps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aeps_pkg;

    // Default sizing
    localparam int MAX_LEVELS_DEF  = 8;
    localparam int LEVEL_DEPTH_DEF = 16;

    // Fixed field widths
    localparam int CFG_W    = 4;
    localparam int TASK_W   = 6;
    localparam int LEVEL_W  = 4;
    localparam int NEWLVL_W = 3;

    localparam logic [CFG_W-1:0] NUM_LEVELS_RST = 4'd4;

    // Request codes
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aeps_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Task id store for all queues: one port, write or registered read
module aeps_store #(
    parameter int DEPTH = 2 * aeps_pkg::MAX_LEVELS_DEF * aeps_pkg::LEVEL_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             addr,
    input  wire logic [aeps_pkg::TASK_W-1:0] wr_data,
    output logic      [aeps_pkg::TASK_W-1:0] rd_data
);

    logic [aeps_pkg::TASK_W-1:0] mem [DEPTH];
    logic [aeps_pkg::TASK_W-1:0] rd_data_reg;

    // Write the tail entry, or fetch the head entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/active_expired_priority_scheduler_unit.sv =====
// Active/expired priority-array scheduler.
// Input channel (in_valid/in_ready): action 0 adds task_id at dynamic_level of the
// active bank, or, when dynamic_level is negative, at static_level - 1 of the
// expired bank. Action 1 takes the head of the highest non-empty active level,
// swapping the banks once if the active levels in use are all empty.
// Output channel (out_valid/out_ready): one result transaction per request.
// Config channel (cfg_valid/cfg_ready/cfg_data): num_levels, always ready; write
// it only while the block is idle.
// Sequence: an add goes from S_ADD to S_FINISH; a take scans the active levels
// from the top down in S_SCAN, at most two full passes of the levels in use,
// reads the task it finds from the store in S_READ, then reaches S_FINISH; a take
// that finds nothing goes from S_SCAN straight to S_FINISH. The scan checks one
// queue count per cycle and the task store has a single port. in_ready is high
// only while no request is in progress, and the next request is taken the cycle
// after the result is handed to the output register.
// Reset: all queues empty, bank 0 active, num_levels 4; no clearing pass.
// A stalled receiver holds the result in the output register; a further
// result waits in the sequencer until that register is free.
`timescale 1ns / 1ps
`default_nettype none

`include "active_expired_priority_scheduler_unit_macros.svh"

module active_expired_priority_scheduler_unit #(
    parameter int MAX_LEVELS  = aeps_pkg::MAX_LEVELS_DEF,
    parameter int LEVEL_DEPTH = aeps_pkg::LEVEL_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // request channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 action,
    input  wire logic        [aeps_pkg::TASK_W-1:0]   task_id,
    input  wire logic signed [aeps_pkg::LEVEL_W-1:0]  dynamic_level,
    input  wire logic        [aeps_pkg::LEVEL_W-1:0]  static_level,
    // result channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic             [1:0]                    status,
    output logic             [aeps_pkg::TASK_W-1:0]   picked_task,
    output logic             [aeps_pkg::NEWLVL_W-1:0] new_level,
    output logic                                      went_expired,
    output logic                                      banks_swapped,
    // configuration channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [aeps_pkg::CFG_W-1:0]    cfg_data
);

    localparam int QN        = 2 * MAX_LEVELS;
    localparam int QW        = $clog2(QN);
    localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PW        = $clog2(LEVEL_DEPTH);
    localparam int CW        = $clog2(LEVEL_DEPTH + 1);
    localparam int SW        = CW + 1;
    localparam int SN        = QN * LEVEL_DEPTH;
    localparam int AW        = $clog2(SN);
    localparam int MAX_CLAMP = (MAX_LEVELS < 15) ? MAX_LEVELS : 15;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ADD    = 5'b00010,
        S_SCAN   = 5'b00100,
        S_READ   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                          state_reg;
    logic [aeps_pkg::CFG_W-1:0]      num_levels_reg;
    logic                            active_bank_reg;
    logic [LVL_W-1:0]                lv_reg;
    logic                            pass_reg;
    logic                            swapped_reg;
    logic [QW-1:0]                   hit_q_reg;
    logic                            out_valid_reg;

    logic [PW-1:0]                   heads_reg  [QN];
    logic [CW-1:0]                   counts_reg [QN];

    // latched request
    logic                            action_reg;
    logic [aeps_pkg::TASK_W-1:0]     task_reg;
    logic [aeps_pkg::LEVEL_W-1:0]    dyn_reg;
    logic [aeps_pkg::LEVEL_W-1:0]    static_reg;

    // pending result and output register
    aeps_pkg::status_t               res_status_reg;
    logic [aeps_pkg::TASK_W-1:0]     res_task_reg;
    logic [aeps_pkg::NEWLVL_W-1:0]   res_level_reg;
    logic                            res_expired_reg;
    logic                            res_swapped_reg;
    aeps_pkg::status_t               out_status_reg;
    logic [aeps_pkg::TASK_W-1:0]     out_task_reg;
    logic [aeps_pkg::NEWLVL_W-1:0]   out_level_reg;
    logic                            out_expired_reg;
    logic                            out_swapped_reg;

    logic [aeps_pkg::CFG_W-1:0]      eff_levels;
    logic [LVL_W-1:0]                top_level;
    logic                            in_accept;
    logic                            out_load;

    logic                            to_expired;
    logic [aeps_pkg::LEVEL_W-1:0]    add_level;
    logic                            add_in_range;
    logic                            add_bank;
    logic [QW-1:0]                   add_q;
    logic                            add_full;
    logic                            add_ok;

    logic [QW-1:0]                   scan_q;
    logic [QW-1:0]                   rw_q;
    logic [PW-1:0]                   sel_head;
    logic [CW-1:0]                   sel_count;
    logic                            scan_hit;
    logic [SW-1:0]                   tail_sum;
    logic [PW-1:0]                   tail_pos;
    logic [PW-1:0]                   head_next;
    logic [PW-1:0]                   mem_pos;
    logic [AW-1:0]                   mem_addr;
    logic                            mem_wr;
    logic                            mem_rd;
    logic [aeps_pkg::TASK_W-1:0]     mem_rd_data;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    // Clamp the level count to the range the banks hold
    always_comb
    begin
        if (num_levels_reg == '0)
        begin
            eff_levels = aeps_pkg::CFG_W'(1);
        end
        else if (num_levels_reg > aeps_pkg::CFG_W'(MAX_CLAMP))
        begin
            eff_levels = aeps_pkg::CFG_W'(MAX_CLAMP);
        end
        else
        begin
            eff_levels = num_levels_reg;
        end
    end

    assign top_level = LVL_W'(eff_levels - aeps_pkg::CFG_W'(1));

    // Decode the add target: expired tasks drop to static level minus one
    assign to_expired   = dyn_reg[aeps_pkg::LEVEL_W-1];
    assign add_level    = to_expired ? (static_reg - aeps_pkg::LEVEL_W'(1)) : dyn_reg;
    assign add_in_range = !(to_expired && (static_reg == '0)) && (add_level < eff_levels);
    assign add_bank     = active_bank_reg ^ to_expired;
    assign add_q        = (add_bank ? QW'(MAX_LEVELS) : QW'(0)) + QW'(add_level);
    assign scan_q       = (active_bank_reg ? QW'(MAX_LEVELS) : QW'(0)) + QW'(lv_reg);

    // One queue pointer pair is looked at per cycle
    always_comb
    begin
        unique case (state_reg)
            S_SCAN:  rw_q = scan_q;
            S_READ:  rw_q = hit_q_reg;
            default: rw_q = add_q;
        endcase
    end

    assign sel_head  = heads_reg[rw_q];
    assign sel_count = counts_reg[rw_q];
    assign scan_hit  = (sel_count != '0);
    assign add_full  = (sel_count == CW'(LEVEL_DEPTH));
    assign add_ok    = add_in_range && !add_full;

    // Tail slot and next head, both wrapped at the queue depth
    assign tail_sum  = SW'(sel_head) + SW'(sel_count);
    assign tail_pos  = (tail_sum >= SW'(LEVEL_DEPTH)) ? PW'(tail_sum - SW'(LEVEL_DEPTH))
                                                      : PW'(tail_sum);
    assign head_next = (SW'(sel_head) + SW'(1) == SW'(LEVEL_DEPTH)) ? '0
                                                                    : (sel_head + PW'(1));

    assign mem_pos  = (state_reg == S_SCAN) ? sel_head : tail_pos;
    assign mem_addr = AW'(rw_q) * AW'(LEVEL_DEPTH) + AW'(mem_pos);
    assign mem_wr   = (state_reg == S_ADD) && add_ok;
    assign mem_rd   = (state_reg == S_SCAN) && scan_hit;

    aeps_store #(
        .DEPTH (SN),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr),
        .rd_en   (mem_rd),
        .addr    (mem_addr),
        .wr_data (task_reg),
        .rd_data (mem_rd_data)
    );

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_levels_reg  <= aeps_pkg::NUM_LEVELS_RST;
            active_bank_reg <= 1'b0;
            lv_reg          <= '0;
            pass_reg        <= 1'b0;
            swapped_reg     <= 1'b0;
            hit_q_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                num_levels_reg <= cfg_data;
            end

            // hold the result until the receiver takes it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        lv_reg      <= top_level;
                        pass_reg    <= 1'b0;
                        swapped_reg <= 1'b0;
                        state_reg   <= (action == aeps_pkg::ACT_TAKE) ? S_SCAN : S_ADD;
                    end
                end
                S_ADD:
                begin
                    state_reg <= S_FINISH;
                end
                S_SCAN:
                begin
                    if (scan_hit)
                    begin
                        hit_q_reg <= rw_q;
                        state_reg <= S_READ;
                    end
                    else if (lv_reg != '0)
                    begin
                        lv_reg <= lv_reg - LVL_W'(1);
                    end
                    else if (!pass_reg)
                    begin
                        // swap banks and scan once more
                        active_bank_reg <= !active_bank_reg;
                        swapped_reg     <= 1'b1;
                        pass_reg        <= 1'b1;
                        lv_reg          <= top_level;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Queue pointers: advance tail count on add, pop head on take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QN; i++)
            begin
                heads_reg[i]  <= '0;
                counts_reg[i] <= '0;
            end
        end
        else if (mem_wr)
        begin
            counts_reg[rw_q] <= sel_count + CW'(1);
        end
        else if (state_reg == S_READ)
        begin
            heads_reg[rw_q]  <= head_next;
            counts_reg[rw_q] <= sel_count - CW'(1);
        end
    end

    // Request latch and result assembly
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= action;
            task_reg   <= task_id;
            dyn_reg    <= $unsigned(dynamic_level);
            static_reg <= static_level;
        end

        if (state_reg == S_ADD)
        begin
            if (!add_in_range)
            begin
                res_status_reg <= aeps_pkg::ST_RANGE;
            end
            else if (add_full)
            begin
                res_status_reg <= aeps_pkg::ST_FULL;
            end
            else
            begin
                res_status_reg <= aeps_pkg::ST_OK;
            end
            res_task_reg    <= '0;
            res_level_reg   <= add_ok ? add_level[aeps_pkg::NEWLVL_W-1:0] : '0;
            res_expired_reg <= add_ok && to_expired;
            res_swapped_reg <= 1'b0;
        end
        else if ((state_reg == S_SCAN) && !scan_hit && (lv_reg == '0) && pass_reg)
        begin
            res_status_reg  <= aeps_pkg::ST_EMPTY;
            res_task_reg    <= '0;
            res_level_reg   <= '0;
            res_expired_reg <= 1'b0;
            res_swapped_reg <= swapped_reg;
        end
        else if (state_reg == S_READ)
        begin
            res_status_reg  <= aeps_pkg::ST_OK;
            res_task_reg    <= mem_rd_data;
            res_level_reg   <= '0;
            res_expired_reg <= 1'b0;
            res_swapped_reg <= swapped_reg;
        end

        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_task_reg    <= res_task_reg;
            out_level_reg   <= res_level_reg;
            out_expired_reg <= res_expired_reg;
            out_swapped_reg <= res_swapped_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign picked_task   = out_task_reg;
    assign new_level     = out_level_reg;
    assign went_expired  = out_expired_reg;
    assign banks_swapped = out_swapped_reg;

    // Checks on sequencing and result consistency
    `AEPS_ASSERT_NXT(a_take_scans, in_accept && (action == aeps_pkg::ACT_TAKE), state_reg == S_SCAN)
    `AEPS_ASSERT_IMP(a_add_path, (state_reg == S_ADD) || (state_reg == S_READ), action_reg == (state_reg == S_READ))
    `AEPS_ASSERT_IMP(a_second_pass, (state_reg == S_SCAN) && pass_reg, swapped_reg)
    `AEPS_ASSERT_IMP(a_empty_swaps, out_valid && (status == aeps_pkg::ST_EMPTY), banks_swapped && (picked_task == '0))
    `AEPS_ASSERT_IMP(a_expired_ok, out_valid && went_expired, (status == aeps_pkg::ST_OK) && !banks_swapped)

endmodule

`default_nettype wire
